/* design/pfsc_pkg.sv */
// Shared types, constants and cell arithmetic for the Playfair stream cipher.
package pfsc_pkg;

    localparam int NumLetters = 26;
    localparam int SqDepth    = 25;
    localparam int LtrW       = 5;

    localparam logic [LtrW-1:0] LtrA    = 5'd0;
    localparam logic [LtrW-1:0] LtrI    = 5'd8;
    localparam logic [LtrW-1:0] LtrJ    = 5'd9;
    localparam logic [LtrW-1:0] LtrX    = 5'd23;
    localparam logic [LtrW-1:0] LtrZ    = 5'd25;
    localparam logic [LtrW-1:0] SqCells = 5'd25;

    typedef enum logic [2:0] {
        CMD_CLEAR = 3'd0,
        CMD_KEY   = 3'd1,
        CMD_CLOSE = 3'd2,
        CMD_TEXT  = 3'd3,
        CMD_END   = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLOSE,
        ST_RD_A,
        ST_RD_B,
        ST_CALC,
        ST_SQ_A,
        ST_SQ_B,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic place_key;
        logic walk_start;
        logic walk_step;
        logic set_ready;
        logic hold_load;
        logic held_drop;
        logic pair_load;
        logic pair_filler;
        logic rd_pos_a;
        logic rd_pos_b;
        logic calc;
        logic rd_sq_a;
        logic rd_sq_b;
        logic out_load;
    } t_ctl;

    typedef struct packed {
        logic square_ready;
        logic held_valid;
        logic held_match;
        logic letter_ok;
        logic walk_last;
        logic out_free;
    } t_status;

    function automatic logic [2:0] f_row(input logic [LtrW-1:0] p);
        logic [2:0] r;
        if (p >= 5'd20) r = 3'd4;
        else if (p >= 5'd15) r = 3'd3;
        else if (p >= 5'd10) r = 3'd2;
        else if (p >= 5'd5) r = 3'd1;
        else r = 3'd0;
        return r;
    endfunction

    function automatic logic [2:0] f_col(input logic [LtrW-1:0] p, input logic [2:0] r);
        logic [LtrW-1:0] t;
        t = p - ({2'b00, r} << 2) - {2'b00, r};
        return t[2:0];
    endfunction

    function automatic logic [2:0] f_step(input logic [2:0] x, input logic back);
        logic [2:0] y;
        if (back) y = (x == 3'd0) ? 3'd4 : x - 3'd1;
        else y = (x == 3'd4) ? 3'd0 : x + 3'd1;
        return y;
    endfunction

    function automatic logic [LtrW-1:0] f_cell(input logic [2:0] r, input logic [2:0] c);
        return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
    endfunction

endpackage

/* design/playfair_stream_cipher.sv */
// Top level of the Playfair stream cipher: controller, datapath and configuration port.
//
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_cmd, i_letter
// result    out        o_out_valid / i_out_ready    o_out_first, o_out_second, o_filler_added
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_data (decrypt mode)
//
// Clear, key letter and non-pairing text items are handled without leaving the idle state.
// A close key request walks all 26 letters, one per cycle.
// A request that completes a pair steps through two position reads and two
// square reads through the single read port of each memory, plus the lookup step.
// Reset is synchronous and active low; it clears the key state, the mode and the result.
// A result waits in the output register while the next requests are taken; a new
// pair stalls in its last step only while that register is still full.
module playfair_stream_cipher (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [2:0]                i_cmd,
    input  logic [pfsc_pkg::LtrW-1:0] i_letter,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [pfsc_pkg::LtrW-1:0] o_out_first,
    output logic [pfsc_pkg::LtrW-1:0] o_out_second,
    output logic                      o_filler_added,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic                      i_cfg_data
);
    import pfsc_pkg::*;

    t_ctl    ctl;
    t_status status;

    assign o_cfg_ready = 1'b1;

    pfsc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_cmd      (i_cmd),
        .i_status   (status),
        .o_ctl      (ctl)
    );

    pfsc_dpath u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl),
        .o_status       (status),
        .i_letter       (i_letter),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_out_first    (o_out_first),
        .o_out_second   (o_out_second),
        .o_filler_added (o_filler_added)
    );

endmodule

/* design/pfsc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module pfsc_ram #(
    parameter int Width = 5,
    parameter int Depth = 25
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);

    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/pfsc_ctrl.sv */
// Controller state machine that sequences key loading, key closing and pair lookups.
module pfsc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [2:0]        i_cmd,
    input  pfsc_pkg::t_status i_status,
    output pfsc_pkg::t_ctl    o_ctl
);
    import pfsc_pkg::*;

    t_state r_state;
    t_state n_state;
    t_ctl   ctl;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        ctl        = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    case (t_cmd'(i_cmd))
                        CMD_CLEAR: begin
                            ctl.clear = 1'b1;
                        end
                        CMD_KEY: begin
                            ctl.place_key = !i_status.square_ready;
                        end
                        CMD_CLOSE: begin
                            if (!i_status.square_ready) begin
                                ctl.walk_start = 1'b1;
                                n_state        = ST_CLOSE;
                            end
                        end
                        CMD_TEXT: begin
                            if (i_status.square_ready && i_status.letter_ok) begin
                                if (!i_status.held_valid) begin
                                    ctl.hold_load = 1'b1;
                                end else if (i_status.held_match) begin
                                    ctl.pair_load   = 1'b1;
                                    ctl.pair_filler = 1'b1;
                                    n_state         = ST_RD_A;
                                end else begin
                                    ctl.pair_load = 1'b1;
                                    ctl.held_drop = 1'b1;
                                    n_state       = ST_RD_A;
                                end
                            end
                        end
                        CMD_END: begin
                            if (i_status.square_ready && i_status.held_valid) begin
                                ctl.pair_load   = 1'b1;
                                ctl.pair_filler = 1'b1;
                                ctl.held_drop   = 1'b1;
                                n_state         = ST_RD_A;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_CLOSE: begin
                ctl.walk_step = 1'b1;
                if (i_status.walk_last) begin
                    ctl.set_ready = 1'b1;
                    n_state       = ST_IDLE;
                end
            end
            ST_RD_A: begin
                ctl.rd_pos_a = 1'b1;
                n_state      = ST_RD_B;
            end
            ST_RD_B: begin
                ctl.rd_pos_b = 1'b1;
                n_state      = ST_CALC;
            end
            ST_CALC: begin
                ctl.calc = 1'b1;
                n_state  = ST_SQ_A;
            end
            ST_SQ_A: begin
                ctl.rd_sq_a = 1'b1;
                n_state     = ST_SQ_B;
            end
            ST_SQ_B: begin
                ctl.rd_sq_b = 1'b1;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    ctl.out_load = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_ctl = ctl;

`ifndef SYNTHESIS
    a_pair_runs_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RD_A) |=> ##3 (r_state == ST_SQ_B))
        else $error("pair lookup sequence broken");
    a_close_needs_open_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLOSE) |-> !i_status.square_ready)
        else $error("key walk while square already closed");
    a_out_waits_for_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && !i_status.out_free) |=> (r_state == ST_OUT))
        else $error("left output state without a free slot");
`endif

endmodule

/* design/pfsc_dpath.sv */
// Datapath with key square and position memories, pair registers and output register.
module pfsc_dpath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pfsc_pkg::t_ctl                i_ctl,
    output pfsc_pkg::t_status             o_status,
    input  logic [pfsc_pkg::LtrW-1:0]     i_letter,
    input  logic                          i_cfg_valid,
    input  logic                          i_cfg_data,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [pfsc_pkg::LtrW-1:0]     o_out_first,
    output logic [pfsc_pkg::LtrW-1:0]     o_out_second,
    output logic                          o_filler_added
);
    import pfsc_pkg::*;

    logic                  r_mode;
    logic [NumLetters-1:0] r_used;
    logic [LtrW-1:0]       r_fill;
    logic                  r_ready;
    logic [LtrW-1:0]       r_held;
    logic                  r_held_valid;
    logic [LtrW-1:0]       r_walk;
    logic [LtrW-1:0]       r_a;
    logic [LtrW-1:0]       r_b;
    logic                  r_filler;
    logic [LtrW-1:0]       r_p1;
    logic [LtrW-1:0]       r_q1;
    logic [LtrW-1:0]       r_q2;
    logic [LtrW-1:0]       r_first;
    logic                  r_out_valid;
    logic [LtrW-1:0]       r_out_first;
    logic [LtrW-1:0]       r_out_second;
    logic                  r_out_filler;

    logic [LtrW-1:0] cand;
    logic            cand_used;
    logic            place_en;
    logic [LtrW-1:0] text_ltr;
    logic [LtrW-1:0] pos_rdata;
    logic [LtrW-1:0] sq_rdata;
    logic            out_free;
    logic [2:0]      row1;
    logic [2:0]      row2;
    logic [2:0]      col1;
    logic [2:0]      col2;
    logic [LtrW-1:0] n_q1;
    logic [LtrW-1:0] n_q2;

    assign cand      = i_ctl.walk_step ? r_walk : i_letter;
    assign cand_used = (cand <= LtrZ) ? r_used[cand] : 1'b1;
    assign place_en  = (i_ctl.place_key || i_ctl.walk_step) && (cand <= LtrZ) &&
                       (cand != LtrJ) && !cand_used && (r_fill < SqCells);
    assign text_ltr  = (i_letter == LtrJ) ? LtrI : i_letter;
    assign out_free  = !r_out_valid || i_out_ready;

    always_comb begin
        row1 = f_row(r_p1);
        row2 = f_row(pos_rdata);
        col1 = f_col(r_p1, row1);
        col2 = f_col(pos_rdata, row2);
        if (col1 == col2) begin
            n_q1 = f_cell(f_step(row1, r_mode), col1);
            n_q2 = f_cell(f_step(row2, r_mode), col2);
        end else if (row1 == row2) begin
            n_q1 = f_cell(row1, f_step(col1, r_mode));
            n_q2 = f_cell(row2, f_step(col2, r_mode));
        end else begin
            n_q1 = f_cell(row1, col2);
            n_q2 = f_cell(row2, col1);
        end
    end

    pfsc_ram #(.Width(LtrW), .Depth(SqDepth)) u_square (
        .i_clk   (i_clk),
        .i_we    (place_en),
        .i_waddr (r_fill),
        .i_wdata (cand),
        .i_re    (i_ctl.rd_sq_a || i_ctl.rd_sq_b),
        .i_raddr (i_ctl.rd_sq_a ? r_q1 : r_q2),
        .o_rdata (sq_rdata)
    );

    pfsc_ram #(.Width(LtrW), .Depth(NumLetters)) u_position (
        .i_clk   (i_clk),
        .i_we    (place_en),
        .i_waddr (cand),
        .i_wdata (r_fill),
        .i_re    (i_ctl.rd_pos_a || i_ctl.rd_pos_b),
        .i_raddr (i_ctl.rd_pos_a ? r_a : r_b),
        .o_rdata (pos_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= 1'b0;
            r_used       <= '0;
            r_fill       <= '0;
            r_ready      <= 1'b0;
            r_held       <= LtrA;
            r_held_valid <= 1'b0;
            r_walk       <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_mode <= i_cfg_data;
            end
            if (i_ctl.clear) begin
                r_used       <= '0;
                r_fill       <= '0;
                r_ready      <= 1'b0;
                r_held       <= LtrA;
                r_held_valid <= 1'b0;
            end else begin
                if (place_en) begin
                    r_used <= r_used | ({{(NumLetters-1){1'b0}}, 1'b1} << cand);
                    r_fill <= r_fill + 5'd1;
                end
                if (i_ctl.set_ready) begin
                    r_ready <= 1'b1;
                end
                if (i_ctl.hold_load) begin
                    r_held       <= text_ltr;
                    r_held_valid <= 1'b1;
                end else if (i_ctl.held_drop) begin
                    r_held_valid <= 1'b0;
                end
            end
            if (i_ctl.walk_start) begin
                r_walk <= '0;
            end else if (i_ctl.walk_step) begin
                r_walk <= r_walk + 5'd1;
            end
            if (i_ctl.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.pair_load) begin
            r_a      <= r_held;
            r_b      <= i_ctl.pair_filler ? LtrX : text_ltr;
            r_filler <= i_ctl.pair_filler;
        end
        if (i_ctl.rd_pos_b) begin
            r_p1 <= pos_rdata;
        end
        if (i_ctl.calc) begin
            r_q1 <= n_q1;
            r_q2 <= n_q2;
        end
        if (i_ctl.rd_sq_b) begin
            r_first <= sq_rdata;
        end
        if (i_ctl.out_load) begin
            r_out_first  <= r_first;
            r_out_second <= sq_rdata;
            r_out_filler <= r_filler;
        end
    end

    assign o_status.square_ready = r_ready;
    assign o_status.held_valid   = r_held_valid;
    assign o_status.held_match   = (r_held == text_ltr);
    assign o_status.letter_ok    = (i_letter <= LtrZ);
    assign o_status.walk_last    = (r_walk == LtrZ);
    assign o_status.out_free     = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_out_first    = r_out_first;
    assign o_out_second   = r_out_second;
    assign o_filler_added = r_out_filler;

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= SqCells)
        else $error("fill count beyond square size");
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> (r_fill == SqCells))
        else $error("square closed but not full");
    a_used_matches_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_used) == int'(r_fill))
        else $error("used letter mask disagrees with fill count");
    a_out_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> r_out_valid)
        else $error("pending result dropped");
`endif

endmodule
